/* rtl/mbx_pkg.sv */
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared types and constants of the dual-processor mailbox: access kinds,
// control word bit positions and the per-transaction event record.
// ----------------------------------------------------------------------------
package mbx_pkg;

  // access kinds
  localparam logic [1:0] KIND_RECV = 2'd0;
  localparam logic [1:0] KIND_SEND = 2'd1;
  localparam logic [1:0] KIND_CTRL = 2'd2;

  // control word bit positions
  localparam int CB_SEND_EMPTY  = 0;
  localparam int CB_SEND_FULL   = 1;
  localparam int CB_SEND_IRQ_EN = 2;
  localparam int CB_CLEAR       = 3;
  localparam int CB_RECV_EMPTY  = 8;
  localparam int CB_RECV_FULL   = 9;
  localparam int CB_RECV_IRQ_EN = 10;
  localparam int CB_ERROR       = 14;
  localparam int CB_ENABLE      = 15;

  // bits that always read as zero
  localparam logic [15:0] CB_RSVD_MASK = 16'h38F8;

  // what one accepted transaction leaves for the response stage
  typedef struct packed {
    logic is_read;
    logic irq_cpu;
    logic irq_se;
    logic irq_rne;
    logic clr_req;
    logic clr_fifo;
  } mbx_evt_t;

endpackage

/* rtl/mbx_in_if.sv */
// ----------------------------------------------------------------------------
// mbx_in_if
// Access channel of the mailbox: one bus access per transaction.
// ----------------------------------------------------------------------------
interface mbx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        cpu_select;
  logic [31:0] write_value;

  modport source (output valid, kind, cpu_select, write_value, input ready);
  modport sink   (input valid, kind, cpu_select, write_value, output ready);
endinterface

/* rtl/mbx_out_if.sv */
// ----------------------------------------------------------------------------
// mbx_out_if
// Response channel of the mailbox: one response per access.
// ----------------------------------------------------------------------------
interface mbx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [15:0] status_word;
  logic        irq_cpu;
  logic        irq_send_empty;
  logic        irq_recv_not_empty;

  modport source (output valid, read_data, status_word, irq_cpu, irq_send_empty,
                  irq_recv_not_empty, input ready);
  modport sink   (input valid, read_data, status_word, irq_cpu, irq_send_empty,
                  irq_recv_not_empty, output ready);
endinterface

/* rtl/dual_cpu_mailbox_fifo.sv */
// ----------------------------------------------------------------------------
// dual_cpu_mailbox_fifo
// Two-processor mailbox with one FIFO_DEPTH-word fifo in each direction.
// Response: the access is captured into the response stage, and the response
//   register is loaded from it once it is free. No new access is taken until
//   then; a clear of a fifo adds a sweep of its FIFO_DEPTH store words.
// Reset: synchronous; afterwards a sweep zeroes all 2*FIFO_DEPTH words of the
//   store, during which no access is taken.
// ----------------------------------------------------------------------------
module dual_cpu_mailbox_fifo import mbx_pkg::*; #(
  parameter int FIFO_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  mbx_in_if.sink    in_ch,
  mbx_out_if.source out_ch
);

  localparam int WORDS  = 2 * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(WORDS - 1);
  localparam logic [ADDR_W-1:0] HALF      = ADDR_W'(FIFO_DEPTH);
  localparam logic [ADDR_W-1:0] HALF_LAST = ADDR_W'(FIFO_DEPTH - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [ADDR_W-1:0] swp_addr_r;
  logic [ADDR_W-1:0] swp_addr_nxt;
  logic [ADDR_W-1:0] swp_last_r;
  logic [ADDR_W-1:0] swp_last_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              cpu_r;
  mbx_evt_t          evt_r;
  logic [31:0]       out_data_r;
  logic [15:0]       out_status_r;
  logic              out_irq_cpu_r;
  logic              out_se_r;
  logic              out_rne_r;

  logic              acc;
  logic              out_load;
  logic [15:0]       status;
  logic              ctrl_rd_en;
  logic              ctrl_wr_en;
  logic [ADDR_W-1:0] ctrl_addr;
  logic [31:0]       ctrl_wdata;
  mbx_evt_t          evt;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       rd_data;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  mbx_ctrl #(.FIFO_DEPTH(FIFO_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .kind        (in_ch.kind),
    .cpu_select  (in_ch.cpu_select),
    .write_value (in_ch.write_value),
    .stat_cpu    (cpu_r),
    .status_word (status),
    .mem_rd_en   (ctrl_rd_en),
    .mem_wr_en   (ctrl_wr_en),
    .mem_addr    (ctrl_addr),
    .mem_wdata   (ctrl_wdata),
    .evt         (evt)
  );

  // sweep owns the write port while clearing
  assign wr_en   = ctrl_wr_en || (state_r == ST_CLR);
  assign wr_addr = (state_r == ST_CLR) ? swp_addr_r : ctrl_addr;
  assign wr_data = (state_r == ST_CLR) ? '0 : ctrl_wdata;

  mbx_mem #(.WORDS(WORDS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl_rd_en),
    .rd_addr (ctrl_addr),
    .rd_data (rd_data)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    swp_addr_nxt = swp_addr_r;
    swp_last_nxt = swp_last_r;
    case (state_r)
      ST_CLR: begin
        if (swp_addr_r == swp_last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          swp_addr_nxt = swp_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          if (evt_r.clr_req) begin
            state_nxt    = ST_CLR;
            swp_addr_nxt = evt_r.clr_fifo ? HALF : '0;
            swp_last_nxt = evt_r.clr_fifo ? ADDR_LAST : HALF_LAST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // response valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      swp_addr_r  <= '0;
      swp_last_r  <= ADDR_LAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      swp_addr_r  <= swp_addr_nxt;
      swp_last_r  <= swp_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction capture and response payload
  always_ff @(posedge clk) begin
    if (acc) begin
      cpu_r <= in_ch.cpu_select;
      evt_r <= evt;
    end
    if (out_load) begin
      out_data_r    <= evt_r.is_read ? rd_data : '0;
      out_status_r  <= status;
      out_irq_cpu_r <= evt_r.irq_cpu;
      out_se_r      <= evt_r.irq_se;
      out_rne_r     <= evt_r.irq_rne;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.read_data          = out_data_r;
  assign out_ch.status_word        = out_status_r;
  assign out_ch.irq_cpu            = out_irq_cpu_r;
  assign out_ch.irq_send_empty     = out_se_r;
  assign out_ch.irq_recv_not_empty = out_rne_r;

  // every accepted transaction moves on to the response stage
  a_acc_resp: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == ST_RESP)) else $error("accepted transaction lost");
  // the sweep never shares the store with an access
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (!ctrl_wr_en && !ctrl_rd_en))
    else $error("store access during sweep");
  // interrupt target reads zero when nothing is raised
  a_irq_cpu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.irq_send_empty && !out_ch.irq_recv_not_empty)
      |-> !out_ch.irq_cpu) else $error("interrupt target without interrupt");
  // reserved status bits stay zero
  a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.status_word & CB_RSVD_MASK) == '0))
    else $error("reserved status bits set");

endmodule

/* rtl/mbx_mem.sv */
// ----------------------------------------------------------------------------
// mbx_mem
// Word store of both FIFOs: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module mbx_mem #(
  parameter int WORDS = 32,
  localparam int ADDR_W = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] store_r [WORDS];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/mbx_ctrl.sv */
// ----------------------------------------------------------------------------
// mbx_ctrl
// Pointers, fill counts and control bits of both sides; decodes one access,
// issues the store access and the event record, and forms the status word.
// ----------------------------------------------------------------------------
module mbx_ctrl import mbx_pkg::*; #(
  parameter int FIFO_DEPTH = 16,
  localparam int ADDR_W = $clog2(2 * FIFO_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [1:0]        kind,
  input  logic              cpu_select,
  input  logic [31:0]       write_value,
  input  logic              stat_cpu,
  output logic [15:0]       status_word,
  output logic              mem_rd_en,
  output logic              mem_wr_en,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [31:0]       mem_wdata,
  output mbx_evt_t          evt
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
  localparam logic [ADDR_W-1:0] BASE_HI  = ADDR_W'(FIFO_DEPTH);

  logic [PTR_W-1:0] rd_ptr_r [2];
  logic [PTR_W-1:0] rd_ptr_nxt [2];
  logic [PTR_W-1:0] wr_ptr_r [2];
  logic [PTR_W-1:0] wr_ptr_nxt [2];
  logic [CNT_W-1:0] cnt_r [2];
  logic [CNT_W-1:0] cnt_nxt [2];
  logic             en_r [2];
  logic             en_nxt [2];
  logic             err_r [2];
  logic             err_nxt [2];
  logic             sie_r [2];
  logic             sie_nxt [2];
  logic             rie_r [2];
  logic             rie_nxt [2];

  logic me;
  logic oth;
  logic se_old;
  logic se_new;
  logic rn_old;
  logic rn_new;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] fifo_addr(input logic f,
                                                  input logic [PTR_W-1:0] p);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(p);
    return f ? (a + BASE_HI) : a;
  endfunction

  assign me        = cpu_select;
  assign oth       = ~cpu_select;
  assign mem_wdata = write_value;

  // access decode and state update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    en_nxt     = en_r;
    err_nxt    = err_r;
    sie_nxt    = sie_r;
    rie_nxt    = rie_r;
    mem_rd_en  = 1'b0;
    mem_wr_en  = 1'b0;
    mem_addr   = '0;
    evt        = '0;
    se_old     = sie_r[me] && (cnt_r[oth] == '0);
    rn_old     = rie_r[me] && (cnt_r[me] != '0);
    se_new     = write_value[CB_SEND_IRQ_EN] &&
                 (write_value[CB_CLEAR] || (cnt_r[oth] == '0));
    rn_new     = write_value[CB_RECV_IRQ_EN] && (cnt_r[me] != '0);
    if (acc) begin
      case (kind)
        KIND_RECV: begin
          evt.is_read = 1'b1;
          mem_rd_en   = 1'b1;
          if (!en_r[me]) begin
            // peek without popping
            mem_addr = fifo_addr(me, rd_ptr_r[me]);
          end else if (cnt_r[me] == '0) begin
            // underflow returns the last word popped
            err_nxt[me] = 1'b1;
            mem_addr    = fifo_addr(me, ptr_dec(rd_ptr_r[me]));
          end else begin
            mem_addr       = fifo_addr(me, rd_ptr_r[me]);
            rd_ptr_nxt[me] = ptr_inc(rd_ptr_r[me]);
            cnt_nxt[me]    = cnt_r[me] - 1'b1;
            if ((cnt_r[me] == CNT_ONE) && sie_r[oth]) begin
              evt.irq_se  = 1'b1;
              evt.irq_cpu = oth;
            end
          end
        end
        KIND_SEND: begin
          if (en_r[me]) begin
            if (cnt_r[oth] == CNT_FULL) begin
              err_nxt[me] = 1'b1;
            end else begin
              mem_wr_en       = 1'b1;
              mem_addr        = fifo_addr(oth, wr_ptr_r[oth]);
              wr_ptr_nxt[oth] = ptr_inc(wr_ptr_r[oth]);
              cnt_nxt[oth]    = cnt_r[oth] + 1'b1;
              if ((cnt_r[oth] == '0) && rie_r[oth]) begin
                evt.irq_rne = 1'b1;
                evt.irq_cpu = oth;
              end
            end
          end
        end
        KIND_CTRL: begin
          en_nxt[me]  = write_value[CB_ENABLE];
          sie_nxt[me] = write_value[CB_SEND_IRQ_EN];
          rie_nxt[me] = write_value[CB_RECV_IRQ_EN];
          err_nxt[me] = err_r[me] & ~write_value[CB_ERROR];
          // clear of the outgoing fifo; the store is swept afterwards
          if (write_value[CB_CLEAR]) begin
            rd_ptr_nxt[oth] = '0;
            wr_ptr_nxt[oth] = '0;
            cnt_nxt[oth]    = '0;
            evt.clr_req     = 1'b1;
            evt.clr_fifo    = oth;
          end
          evt.irq_se  = !se_old && se_new;
          evt.irq_rne = !rn_old && rn_new;
          evt.irq_cpu = me && ((!se_old && se_new) || (!rn_old && rn_new));
        end
        default: begin
        end
      endcase
    end
  end

  // status word of the selected side
  always_comb begin
    status_word                 = '0;
    status_word[CB_SEND_EMPTY]  = (cnt_r[~stat_cpu] == '0);
    status_word[CB_SEND_FULL]   = (cnt_r[~stat_cpu] == CNT_FULL);
    status_word[CB_SEND_IRQ_EN] = sie_r[stat_cpu];
    status_word[CB_RECV_EMPTY]  = (cnt_r[stat_cpu] == '0);
    status_word[CB_RECV_FULL]   = (cnt_r[stat_cpu] == CNT_FULL);
    status_word[CB_RECV_IRQ_EN] = rie_r[stat_cpu];
    status_word[CB_ERROR]       = err_r[stat_cpu];
    status_word[CB_ENABLE]      = en_r[stat_cpu];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        cnt_r[i]    <= '0;
        en_r[i]     <= 1'b0;
        err_r[i]    <= 1'b0;
        sie_r[i]    <= 1'b0;
        rie_r[i]    <= 1'b0;
      end
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
      en_r     <= en_nxt;
      err_r    <= err_nxt;
      sie_r    <= sie_nxt;
      rie_r    <= rie_nxt;
    end
  end

  // fill counts stay within the fifo depth
  a_cnt0_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_FULL) else $error("fifo 0 fill count out of range");
  a_cnt1_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[1] <= CNT_FULL) else $error("fifo 1 fill count out of range");
  // store access only for an accepted transaction
  a_mem_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en || mem_wr_en) |-> acc) else $error("store access without transaction");

endmodule

/* test/dual_cpu_mailbox_fifo_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_cpu_mailbox_fifo_test
// Self-checking bench for the two-processor mailbox. A scoreboard class keeps
// its own copy of both fifos and both control words, predicts the response
// of every accepted access and checks responses in order. Stimulus is a short
// directed pass over flags, overflow, underflow and clear, then phased random
// traffic that fills and drains the fifos under random idle and stall.
// ----------------------------------------------------------------------------
module dual_cpu_mailbox_fifo_test;
  import mbx_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1675;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PCT     = 23;

  // access kind the block leaves unused
  localparam logic [1:0] KIND_NONE = 2'd3;

  // control word masks built from the bit positions
  localparam logic [15:0] CW_ENABLE   = 16'h1 << CB_ENABLE;
  localparam logic [15:0] CW_CLEAR    = 16'h1 << CB_CLEAR;
  localparam logic [15:0] CW_ERROR    = 16'h1 << CB_ERROR;
  localparam logic [15:0] CW_WRITABLE = (16'h1 << CB_SEND_IRQ_EN) |
                                        (16'h1 << CB_RECV_IRQ_EN) | CW_ENABLE;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  typedef struct {
    logic [31:0] read_data;
    logic [15:0] status_word;
    logic        irq_cpu;
    logic        irq_send_empty;
    logic        irq_recv_not_empty;
  } mbx_resp_t;

  // --------------------------------------------------------------------------
  // scoreboard: mailbox state copy and queue of predicted responses
  // --------------------------------------------------------------------------
  class mbx_scoreboard;
    logic [31:0]      store [2][DEPTH];
    logic [PTR_W-1:0] rd_ptr [2];
    logic [PTR_W-1:0] wr_ptr [2];
    int               fill [2];
    logic [15:0]      ctrl [2];
    mbx_resp_t        pending_responses [$];
    int               errors, checked;
    int               n_kind [4];
    int               n_full_sends, n_empty_reads, n_clears, n_irqs;

    function new();
      foreach (store[f, i]) store[f][i] = '0;
      for (int f = 0; f < 2; f++) begin
        rd_ptr[f] = '0;
        wr_ptr[f] = '0;
        fill[f]   = 0;
        ctrl[f]   = 16'h0101;
      end
      foreach (n_kind[k]) n_kind[k] = 0;
      errors = 0; checked = 0;
      n_full_sends = 0; n_empty_reads = 0; n_clears = 0; n_irqs = 0;
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction

    // predict the response of one accepted access and update the state copy
    function void note_access(logic [1:0] kind, bit me, logic [31:0] val);
      mbx_resp_t        r;
      bit               other;
      logic [PTR_W-1:0] prev;
      logic [15:0]      v, c;
      logic             se_old, rn_old, se_new, rn_new;
      other = ~me;
      r = '{default: '0};
      n_kind[kind]++;
      case (kind)
        KIND_RECV: begin
          // receive from fifo me, the partner is the sender
          if (!ctrl[me][CB_ENABLE]) begin
            r.read_data = store[me][rd_ptr[me]];
          end else if (fill[me] == 0) begin
            ctrl[me][CB_ERROR] = 1'b1;
            prev = rd_ptr[me] - 1'b1;
            r.read_data = store[me][prev];
            n_empty_reads++;
          end else begin
            r.read_data = store[me][rd_ptr[me]];
            rd_ptr[me]++;
            fill[me]--;
            if (fill[me] == DEPTH - 1) begin
              ctrl[other][CB_SEND_FULL] = 1'b0;
              ctrl[me][CB_RECV_FULL]    = 1'b0;
            end
            if (fill[me] == 0) begin
              ctrl[other][CB_SEND_EMPTY] = 1'b1;
              ctrl[me][CB_RECV_EMPTY]    = 1'b1;
              if (ctrl[other][CB_SEND_IRQ_EN]) begin
                r.irq_send_empty = 1'b1;
                r.irq_cpu        = other;
              end
            end
          end
        end
        KIND_SEND: begin
          // send into fifo other, dropped while disabled
          if (ctrl[me][CB_ENABLE]) begin
            if (fill[other] >= DEPTH) begin
              ctrl[me][CB_ERROR] = 1'b1;
              n_full_sends++;
            end else begin
              store[other][wr_ptr[other]] = val;
              wr_ptr[other]++;
              fill[other]++;
              if (fill[other] == DEPTH) begin
                ctrl[me][CB_SEND_FULL]    = 1'b1;
                ctrl[other][CB_RECV_FULL] = 1'b1;
              end
              if (fill[other] == 1) begin
                ctrl[me][CB_SEND_EMPTY]    = 1'b0;
                ctrl[other][CB_RECV_EMPTY] = 1'b0;
                if (ctrl[other][CB_RECV_IRQ_EN]) begin
                  r.irq_recv_not_empty = 1'b1;
                  r.irq_cpu            = other;
                end
              end
            end
          end
        end
        KIND_CTRL: begin
          v = val[15:0];
          c = ctrl[me];
          se_old = c[CB_SEND_IRQ_EN] && c[CB_SEND_EMPTY];
          rn_old = c[CB_RECV_IRQ_EN] && !c[CB_RECV_EMPTY];
          c = (c & ~CW_WRITABLE) | (v & CW_WRITABLE);
          c = c & ~(v & CW_ERROR);
          ctrl[me] = c;
          // clear of the outgoing fifo zeroes its store
          if (v[CB_CLEAR]) begin
            for (int i = 0; i < DEPTH; i++) store[other][i] = '0;
            rd_ptr[other] = '0;
            wr_ptr[other] = '0;
            fill[other]   = 0;
            ctrl[me][CB_SEND_FULL]     = 1'b0;
            ctrl[other][CB_RECV_FULL]  = 1'b0;
            ctrl[me][CB_SEND_EMPTY]    = 1'b1;
            ctrl[other][CB_RECV_EMPTY] = 1'b1;
            n_clears++;
          end
          // interrupts on rising conditions go to the writer
          c = ctrl[me];
          se_new = c[CB_SEND_IRQ_EN] && c[CB_SEND_EMPTY];
          rn_new = c[CB_RECV_IRQ_EN] && !c[CB_RECV_EMPTY];
          r.irq_send_empty     = !se_old && se_new;
          r.irq_recv_not_empty = !rn_old && rn_new;
          if (r.irq_send_empty || r.irq_recv_not_empty) r.irq_cpu = me;
        end
        default: ;
      endcase
      r.status_word = ctrl[me];
      if (r.irq_send_empty || r.irq_recv_not_empty) n_irqs++;
      pending_responses.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
        errors++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // compare one accepted response with the oldest prediction
    function void check_response(mbx_resp_t got);
      mbx_resp_t exp;
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, got data %h status %h",
                 $time, got.read_data, got.status_word);
        errors++;
        return;
      end
      exp = pending_responses.pop_front();
      checked++;
      void'(field_ok("read_data", exp.read_data, got.read_data));
      void'(field_ok("status_word", exp.status_word, got.status_word));
      void'(field_ok("irq_cpu", exp.irq_cpu, got.irq_cpu));
      void'(field_ok("irq_send_empty", exp.irq_send_empty, got.irq_send_empty));
      void'(field_ok("irq_recv_not_empty", exp.irq_recv_not_empty,
                     got.irq_recv_not_empty));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  bit   hold_req;
  int   hold_left;
  int   stall_cycles = 0;

  mbx_in_if  in_ch ();
  mbx_out_if out_ch ();

  mbx_scoreboard sb = new();

  dual_cpu_mailbox_fifo #(.FIFO_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always #10 clk = ~clk;

  // transaction monitor on both channels
  always @(posedge clk) begin
    mbx_resp_t got;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.read_data          = out_ch.read_data;
        got.status_word        = out_ch.status_word;
        got.irq_cpu            = out_ch.irq_cpu;
        got.irq_send_empty     = out_ch.irq_send_empty;
        got.irq_recv_not_empty = out_ch.irq_recv_not_empty;
        sb.check_response(got);
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.note_access(in_ch.kind, in_ch.cpu_select, in_ch.write_value);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // response side: random stall, one long hold-off on request
  initial begin
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else
        out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // offer one access, with random idle cycles in front of it
  task automatic put_access(logic [1:0] kind, bit cpu, logic [31:0] val);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.cpu_select  <= cpu;
    in_ch.write_value <= val;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // stop offering until every predicted response has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    traffic_mode_t mode;
    int            mode_left, roll, send_pct, recv_pct, n;
    bit            lead, cpu;
    logic [1:0]    kind;
    logic [31:0]   val;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_RECV;
    in_ch.cpu_select  <= 1'b0;
    in_ch.write_value <= '0;
    steady            = 1'b0;
    hold_req          = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: disabled peek and send, unused kind, enables and clear
    put_access(KIND_RECV, 1'b0, 32'h0);
    put_access(KIND_SEND, 1'b1, 32'hDEAD_BEEF);
    put_access(KIND_NONE, 1'b1, 32'hFFFF_FFFF);
    put_access(KIND_CTRL, 1'b0, 32'hFFFF_FFFF);
    put_access(KIND_CTRL, 1'b1, {16'h0, CW_WRITABLE});
    // fill fifo 1 to the brim, then overflow it
    for (n = 0; n < DEPTH; n++) begin
      if (n == 0) val = 32'hFFFF_FFFF;
      else if (n == 1) val = 32'h0;
      else val = n[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
      put_access(KIND_SEND, 1'b0, val);
    end
    put_access(KIND_SEND, 1'b0, 32'h1234_5678);
    put_access(KIND_RECV, 1'b1, 32'h0);
    // clear while not empty, then read the emptied fifo
    put_access(KIND_CTRL, 1'b0, {16'h0, CW_ENABLE | CW_CLEAR | CW_ERROR});
    put_access(KIND_RECV, 1'b1, 32'h0);
    wait_drained();

    // random traffic in fill, drain and mixed phases
    mode_left = 0;
    mode = MODE_MIX;
    lead = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_req = 1'b1;
      steady = (n >= 800 && n < 1100);
      if (n == 1250) wait_drained();
      if (mode_left == 0) begin
        mode      = traffic_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 60);
        lead      = $urandom_range(0, 1);
      end
      mode_left--;

      case (mode)
        MODE_FILL: begin
          send_pct = 65; recv_pct = 20;
        end
        MODE_DRAIN: begin
          send_pct = 20; recv_pct = 65;
        end
        default: begin
          send_pct = 42; recv_pct = 42;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < send_pct) kind = KIND_SEND;
      else if (roll < send_pct + recv_pct) kind = KIND_RECV;
      else if (roll < 97) kind = KIND_CTRL;
      else kind = KIND_NONE;

      // sends mostly from the lead side, receives on the other
      if (mode != MODE_MIX && $urandom_range(0, 99) < 85)
        cpu = (kind == KIND_RECV) ? ~lead : lead;
      else
        cpu = $urandom_range(0, 1);

      val  = $urandom;
      roll = $urandom_range(0, 99);
      if (kind == KIND_CTRL) begin
        val[CB_ENABLE] = (roll < 90);
        val[CB_CLEAR]  = ($urandom_range(0, 99) < 15);
      end else if (roll < 5)
        val = 32'h0;
      else if (roll < 10)
        val = 32'hFFFF_FFFF;
      put_access(kind, cpu, val);
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("Run covered %0d receives, %0d sends, %0d control writes, %0d unused kinds;",
             sb.n_kind[KIND_RECV], sb.n_kind[KIND_SEND], sb.n_kind[KIND_CTRL],
             sb.n_kind[KIND_NONE]);
    $display("%0d responses checked, %0d full sends, %0d empty reads, %0d clears, %0d irqs.",
             sb.checked, sb.n_full_sends, sb.n_empty_reads, sb.n_clears, sb.n_irqs);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
